/* rtl/ustda_pkg.sv */
// Shared constants and types for the unsigned-to-decimal ASCII converter.
package ustda_pkg;

    localparam int NUM_WIDTH   = 32;
    localparam int MAX_DIGITS  = 10;
    localparam int BCD_WIDTH   = 4 * MAX_DIGITS;
    localparam int CHAR_WIDTH  = 6;
    localparam int CNT_WIDTH   = $clog2(NUM_WIDTH);
    localparam int LEFT_WIDTH  = $clog2(MAX_DIGITS + 1);
    localparam int ASCII_ZERO  = 48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

endpackage

/* rtl/ustda_dabble.sv */
// Bit-serial double-dabble: binary in, packed BCD out, one input bit per cycle.
module ustda_dabble (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [ustda_pkg::NUM_WIDTH-1:0]    i_number,
    output logic                               o_done,
    output logic [ustda_pkg::BCD_WIDTH-1:0]    o_bcd
);

    logic [ustda_pkg::NUM_WIDTH-1:0] r_num;
    logic [ustda_pkg::BCD_WIDTH-1:0] r_bcd;
    logic [ustda_pkg::BCD_WIDTH-1:0] n_adj;
    logic [ustda_pkg::CNT_WIDTH-1:0] r_cnt;
    logic                            r_busy;
    logic                            r_done;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < ustda_pkg::MAX_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ustda_pkg::CNT_WIDTH'(ustda_pkg::NUM_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_number;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[ustda_pkg::NUM_WIDTH-2:0], 1'b0};
            r_bcd <= {n_adj[ustda_pkg::BCD_WIDTH-2:0], r_num[ustda_pkg::NUM_WIDTH-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

/* rtl/ustda_emit.sv */
// Digit emitter: shifts BCD out MSD first, drops leading zeros, drives the output register.
module ustda_emit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [ustda_pkg::BCD_WIDTH-1:0]     i_bcd,
    output logic                                o_busy,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ustda_pkg::CHAR_WIDTH-1:0]    o_ascii_char,
    output logic                                o_last_digit
);

    logic [ustda_pkg::BCD_WIDTH-1:0]  r_bcd;
    logic [ustda_pkg::LEFT_WIDTH-1:0] r_left;
    logic                             r_seen;
    logic                             r_busy;
    logic                             r_valid;
    logic [ustda_pkg::CHAR_WIDTH-1:0] r_char;
    logic                             r_last;
    logic [3:0]                       n_digit;
    logic                             n_step;
    logic                             n_final;
    logic                             n_show;

    always_comb begin
        n_digit = r_bcd[ustda_pkg::BCD_WIDTH-1 -: 4];
        n_step  = r_busy && (!r_valid || i_ready);
        n_final = (r_left == ustda_pkg::LEFT_WIDTH'(1));
        // the last digit always shows, so zero gives a single '0'
        n_show  = r_seen || n_final || (n_digit != 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= 1'b1;
            end else if (n_step && n_final) begin
                r_busy <= 1'b0;
            end
            // a new character replaces one taken in the same cycle
            if (!i_load && n_step && n_show) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bcd  <= i_bcd;
            r_left <= ustda_pkg::LEFT_WIDTH'(ustda_pkg::MAX_DIGITS);
            r_seen <= 1'b0;
        end else if (n_step) begin
            r_bcd  <= {r_bcd[ustda_pkg::BCD_WIDTH-5:0], 4'd0};
            r_left <= r_left - 1'b1;
            if (n_show) begin
                r_seen <= 1'b1;
                r_char <= ustda_pkg::CHAR_WIDTH'(ustda_pkg::ASCII_ZERO)
                          + ustda_pkg::CHAR_WIDTH'(n_digit);
                r_last <= n_final;
            end
        end
    end

    assign o_busy       = r_busy;
    assign o_valid      = r_valid;
    assign o_ascii_char = r_char;
    assign o_last_digit = r_last;

endmodule

/* rtl/unsigned_to_decimal_ascii_core.sv */
// Top level: 32-bit unsigned binary to decimal ASCII digit stream.
//
// Input channel (i_valid / o_ready, i_number) takes one 32-bit unsigned value.
// Output channel (o_valid / i_ready) gives its decimal text, one item per
// digit: o_ascii_char is '0'..'9', most significant digit first, without
// leading zeros; o_last_digit marks the least significant digit. Zero gives
// a single '0'. One number yields 1 to 10 output items.
// Timing with an always-ready receiver: the double-dabble unit shifts one
// input bit per cycle over the whole input word, then the emitter walks all 10 BCD
// digit slots at one per cycle (leading zeros are consumed without output).
// A new number is accepted only once the emitter has walked every digit
// slot of the previous one; conversion and emission do not overlap.
// The bit-serial shift loop and the 10-slot digit walk set the rate.
// A stalled receiver holds the emitter on its current digit; the last
// character of a number sits in the output register while the next number
// is accepted and converted.
// Reset (i_rst_n low, synchronous) returns to idle and drops any item in flight.
module unsigned_to_decimal_ascii_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ustda_pkg::NUM_WIDTH-1:0]     i_number,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ustda_pkg::CHAR_WIDTH-1:0]    o_ascii_char,
    output logic                                o_last_digit
);

    ustda_pkg::t_state               r_state;
    ustda_pkg::t_state               n_state;
    logic                            n_start;
    logic                            dab_done;
    logic [ustda_pkg::BCD_WIDTH-1:0] dab_bcd;
    logic                            emit_busy;

    // sequencer: idle -> convert -> emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ustda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        n_start = 1'b0;
        unique case (r_state)
            ustda_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_start = 1'b1;
                    n_state = ustda_pkg::ST_CONV;
                end
            end
            ustda_pkg::ST_CONV: begin
                // BCD is loaded into the emitter on the done pulse
                if (dab_done) begin
                    n_state = ustda_pkg::ST_EMIT;
                end
            end
            ustda_pkg::ST_EMIT: begin
                // free once the last digit is in the output register
                if (!emit_busy) begin
                    n_state = ustda_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ustda_pkg::ST_IDLE;
            end
        endcase
    end

    ustda_dabble u_dabble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (n_start),
        .i_number (i_number),
        .o_done   (dab_done),
        .o_bcd    (dab_bcd)
    );

    ustda_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (dab_done),
        .i_bcd        (dab_bcd),
        .o_busy       (emit_busy),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ascii_char (o_ascii_char),
        .o_last_digit (o_last_digit)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the unsigned-to-decimal ASCII converter.
module tb;

    typedef struct packed {
        logic [ustda_pkg::CHAR_WIDTH-1:0] code;
        logic                             last;
    } t_digit_item;

    // Holds the digit characters still owed by the converter, oldest first.
    class digit_board;
        t_digit_item digits_due[$];
        int unsigned fails;
        int unsigned checked;

        function new();
            fails   = 0;
            checked = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            fails++;
        endtask

        // Queue the decimal text of an accepted number, most significant digit first.
        function void note_number(logic [ustda_pkg::NUM_WIDTH-1:0] value);
            int unsigned rest;
            int unsigned dec[$];
            t_digit_item item;
            rest = value;
            do begin
                dec.push_front(rest % 10);
                rest = rest / 10;
            end while (rest != 0 && dec.size() < ustda_pkg::MAX_DIGITS);
            for (int i = 0; i < dec.size(); i++) begin
                item.code = ustda_pkg::CHAR_WIDTH'(dec[i] + ustda_pkg::ASCII_ZERO);
                item.last = (i == dec.size() - 1);
                digits_due.push_back(item);
            end
        endfunction

        task check_digit(logic [ustda_pkg::CHAR_WIDTH-1:0] code, logic last);
            t_digit_item want;
            checked++;
            if (digits_due.size() == 0) begin
                report($sformatf("item %0d: char %0d with nothing pending", checked, code));
            end else begin
                want = digits_due.pop_front();
                if (code !== want.code)
                    report($sformatf("item %0d: char %0d, want %0d", checked, code, want.code));
                if (last !== want.last)
                    report($sformatf("item %0d: last %b, want %b", checked, last, want.last));
            end
        endtask
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_ready;
    logic [ustda_pkg::NUM_WIDTH-1:0]  i_number = '0;
    logic                             o_valid;
    logic                             i_ready = 1'b0;
    logic [ustda_pkg::CHAR_WIDTH-1:0] o_ascii_char;
    logic                             o_last_digit;

    // No idling on either side while calm is set.
    logic                  calm = 1'b0;

    digit_board board = new();

    unsigned_to_decimal_ascii_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_number     (i_number),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ascii_char (o_ascii_char),
        .o_last_digit (o_last_digit)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random back-pressure, stalled with a chance of about 16 in a hundred.
    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 16);
    end

    // Every output item goes straight to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_digit(o_ascii_char, o_last_digit);
    end

    // Offer one number; returns at the edge where it is accepted.
    task automatic push_number(input logic [ustda_pkg::NUM_WIDTH-1:0] value);
        while (!calm && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_number <= value;
        do @(posedge i_clk); while (!o_ready);
        board.note_number(value);
    endtask

    function automatic longint unsigned pow10(int n);
        longint unsigned p;
        p = 1;
        repeat (n) p = p * 10;
        return p;
    endfunction

    // Random number shaped to spread over every digit count and the decade edges.
    function automatic logic [ustda_pkg::NUM_WIDTH-1:0] pick_number();
        longint unsigned lo;
        longint unsigned hi;
        int              n;
        int              mode;
        mode = $urandom_range(99);
        if (mode < 50) begin
            n  = $urandom_range(10, 1);
            lo = (n == 1) ? 0 : pow10(n - 1);
            hi = pow10(n) - 1;
            if (hi > 64'hFFFF_FFFF)
                hi = 64'hFFFF_FFFF;
            return ustda_pkg::NUM_WIDTH'(lo + ({32'b0, $urandom} % (hi - lo + 1)));
        end else if (mode < 75) begin
            return $urandom;
        end else if (mode < 90) begin
            // Just around a power of ten
            n  = $urandom_range(9, 0);
            lo = pow10(n) + $urandom_range(2) - 1;
            return ustda_pkg::NUM_WIDTH'(lo);
        end else begin
            return 32'h1 << $urandom_range(31);
        end
    endfunction

    logic [ustda_pkg::NUM_WIDTH-1:0] directed_numbers[$] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd909,
        32'd1000, 32'd99999, 32'd100000, 32'd999999999, 32'd1000000000,
        32'd1234567890, 32'd4000000000, 32'd4294967294, 32'hFFFF_FFFF,
        32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd102030405, 32'd0
    };

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, decade edges, all-ones and alternating bit patterns
        foreach (directed_numbers[i])
            push_number(directed_numbers[i]);

        // Random, with a stretch of back-to-back traffic in the middle
        for (int i = 0; i < 350; i++) begin
            if (i == 120)
                calm <= 1'b1;
            else if (i == 190)
                calm <= 1'b0;
            push_number(pick_number());
        end
        i_valid <= 1'b0;

        // Drain, then allow one full conversion time for stray output
        while (board.digits_due.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (board.fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run under full random stalls.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
